// ===== src/qmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_pkg: shared definitions for the int8 quantized matrix multiplier
// Sizes, widths, codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package qmm_pkg;

	// matrix store dimensions
	localparam int MAX_ROWS  = 8;
	localparam int MAX_INNER = 8;
	localparam int MAX_COLS  = 8;

	// counter and index widths
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int INNER_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// store geometry
	localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
	localparam int B_DEPTH = MAX_INNER * MAX_COLS;
	localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

	// field widths
	localparam int OPC_W   = 2;
	localparam int IDX_W   = 3;
	localparam int ELEM_W  = 8;
	localparam int SIZE_W  = 4;
	localparam int MANT_W  = 31;
	localparam int SHIFT_W = 6;

	// datapath widths
	localparam int DIFF_W = ELEM_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int ACC_W  = PROD_W + INNER_W;
	localparam int MUL_W  = ACC_W + MANT_W;
	localparam int SUM_W  = 64;
	localparam int TSH_W  = 7;
	localparam int FRAC_BITS = 31;
	localparam int MAX_SHIFT = 63;
	localparam int Q_W    = 8;
	localparam int R_W    = 11;

	// output clamp range
	localparam int QMAX = 127;
	localparam int QMIN = -128;

	// configuration port
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 5;

	// stream word widths
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_RUN    = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		REG_A_OFFSET   = 3'd0,
		REG_B_OFFSET   = 3'd1,
		REG_Y_OFFSET   = 3'd2,
		REG_SCALE_MANT = 3'd3,
		REG_SCALE_SHFT = 3'd4,
		REG_ROWS_USED  = 3'd5,
		REG_INNER_USED = 3'd6,
		REG_COLS_USED  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_REQ
	} state_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a_offset;
		logic signed [ELEM_W-1:0] b_offset;
		logic signed [ELEM_W-1:0] y_offset;
		logic [MANT_W-1:0]        scale_mantissa;
		logic [SHIFT_W-1:0]       scale_shift;
		logic [SIZE_W-1:0]        rows_used;
		logic [SIZE_W-1:0]        inner_used;
		logic [SIZE_W-1:0]        cols_used;
	} cfg_t;

	typedef struct packed {
		logic               wr_a;
		logic               wr_b;
		logic               rd;
		logic               first;
		logic               req_go;
		logic               out_load;
		logic               last;
		logic [ROW_W-1:0]   row_idx;
		logic [INNER_W-1:0] inner_idx;
		logic [COL_W-1:0]   col_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic mac_busy;
		logic res_valid;
		logic out_free;
	} dp_sts_t;

	// clip a size register write into [1, top]
	function automatic logic [SIZE_W-1:0] fit_size(input logic [DATA_W-1:0] v, input int top);
		logic [SIZE_W-1:0] x;
		x = v[SIZE_W-1:0];
		if (x == '0) begin
			return SIZE_W'(1);
		end
		if (int'(x) > top) begin
			return SIZE_W'(top);
		end
		return x;
	endfunction

endpackage
`default_nettype wire

// ===== src/qmm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/qmm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_ctrl: sequencer for loads and matrix runs
// Walks rows, columns and the inner index, and steps the datapath through
// accumulate, requantize and output for each result element.
// ----------------------------------------------------------------------------
module qmm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire qmm_pkg::cfg_t             cfg,
	input  wire logic                      in_valid,
	input  wire logic [qmm_pkg::OPC_W-1:0] in_opcode,
	input  wire logic [qmm_pkg::IDX_W-1:0] in_row,
	input  wire logic [qmm_pkg::IDX_W-1:0] in_col,
	output logic                           in_ready,
	input  wire qmm_pkg::dp_sts_t          sts,
	output qmm_pkg::dp_cmd_t               cmd
);
	import qmm_pkg::*;

	state_t             state_q, state_d;
	logic [ROW_W-1:0]   i_q;
	logic [COL_W-1:0]   j_q;
	logic [INNER_W-1:0] k_q;
	logic               accept;
	logic               k_last, j_last, i_last;
	logic               emit;

	assign accept = in_valid && in_ready;
	assign k_last = (int'(k_q) + 1) >= int'(cfg.inner_used);
	assign j_last = (int'(j_q) + 1) >= int'(cfg.cols_used);
	assign i_last = (int'(i_q) + 1) >= int'(cfg.rows_used);
	assign emit   = (state_q == ST_REQ) && sts.res_valid && sts.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_opcode == OP_RUN) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.mac_busy) begin
					state_d = ST_REQ;
				end
			end
			ST_REQ: begin
				if (emit) begin
					state_d = (i_last && j_last) ? ST_IDLE : ST_MAC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.row_idx   = i_q;
		cmd.col_idx   = j_q;
		cmd.inner_idx = k_q;
		cmd.last      = i_last && j_last;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.wr_a = in_valid && in_opcode == OP_LOAD_A
					&& int'(in_row) < MAX_ROWS && int'(in_col) < MAX_INNER;
				cmd.wr_b = in_valid && in_opcode == OP_LOAD_B
					&& int'(in_row) < MAX_INNER && int'(in_col) < MAX_COLS;
			end
			ST_MAC: begin
				cmd.rd    = 1'b1;
				cmd.first = (k_q == '0);
			end
			ST_DRAIN: begin
				cmd.req_go = !sts.mac_busy;
			end
			ST_REQ: begin
				cmd.out_load = emit;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				ST_MAC: begin
					if (!k_last) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_REQ: begin
					if (emit) begin
						k_q <= '0;
						if (j_last) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/qmm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_dp: matrix stores, multiply-accumulate and requantize datapath
// Holds both stores, one MAC lane, a three-stage requantizer and the
// output word register.
// ----------------------------------------------------------------------------
module qmm_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire qmm_pkg::cfg_t              cfg,
	input  wire qmm_pkg::dp_cmd_t           cmd,
	input  wire logic [qmm_pkg::IDX_W-1:0]  in_row,
	input  wire logic [qmm_pkg::IDX_W-1:0]  in_col,
	input  wire logic [qmm_pkg::ELEM_W-1:0] in_element,
	output qmm_pkg::dp_sts_t                sts,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [qmm_pkg::ELEM_W-1:0]      out_value,
	output logic [qmm_pkg::IDX_W-1:0]       out_row,
	output logic [qmm_pkg::IDX_W-1:0]       out_col,
	output logic                            out_last
);
	import qmm_pkg::*;

	logic [A_AW-1:0]          a_waddr, a_raddr;
	logic [B_AW-1:0]          b_waddr, b_raddr;
	logic [ELEM_W-1:0]        a_rdata, b_rdata;

	logic                     rd_s1, first_s1;
	logic                     prod_v_s2, first_s2;
	logic signed [DIFF_W-1:0] a_diff, b_diff;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic [ACC_W-1:0]         mag;
	logic                     req_s1, neg_s1;
	logic [MUL_W-1:0]         mul_s1;
	logic [TSH_W-1:0]         tot_shift;
	logic                     req_s2, neg_s2, big_s2;
	logic [SHIFT_W-1:0]       shamt_s2;
	logic [SUM_W-1:0]         sum_s2;
	logic [SUM_W-1:0]         q_full;
	logic [Q_W-1:0]           q_sat;
	logic signed [R_W-1:0]    r_mag, r_sgn, r_off;
	logic signed [ELEM_W-1:0] r_clamp;
	logic                     res_valid_q;
	logic signed [ELEM_W-1:0] res_q;

	logic                     out_valid_q, out_last_q;
	logic [ELEM_W-1:0]        out_value_q;
	logic [IDX_W-1:0]         out_row_q, out_col_q;

	// store addresses, row-major
	assign a_waddr = A_AW'(int'(in_row) * MAX_INNER + int'(in_col));
	assign b_waddr = B_AW'(int'(in_row) * MAX_COLS + int'(in_col));
	assign a_raddr = A_AW'(int'(cmd.row_idx) * MAX_INNER + int'(cmd.inner_idx));
	assign b_raddr = B_AW'(int'(cmd.inner_idx) * MAX_COLS + int'(cmd.col_idx));

	qmm_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (A_DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (a_waddr),
		.wdata (in_element),
		.re    (cmd.rd),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	qmm_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (B_DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (b_waddr),
		.wdata (in_element),
		.re    (cmd.rd),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// zero-point removal
	assign a_diff = signed'({a_rdata[ELEM_W-1], a_rdata})
		- signed'({cfg.a_offset[ELEM_W-1], cfg.a_offset});
	assign b_diff = signed'({b_rdata[ELEM_W-1], b_rdata})
		- signed'({cfg.b_offset[ELEM_W-1], cfg.b_offset});

	// mac pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1     <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_s1     <= cmd.rd;
			prod_v_s2 <= rd_s1;
		end
	end

	// product register and accumulator
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		first_s2 <= first_s1;
		prod_s2  <= a_diff * b_diff;
		if (prod_v_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// requantize stage 1: magnitude times mantissa
	assign mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	// requantize stage 2: rounding offset
	assign tot_shift = TSH_W'(FRAC_BITS) + TSH_W'(cfg.scale_shift);

	// requantize stage 3: shift, saturate, offset, clamp
	assign q_full  = big_s2 ? '0 : (sum_s2 >> shamt_s2);
	assign q_sat   = (q_full > SUM_W'((1 << Q_W) - 1)) ? '1 : q_full[Q_W-1:0];
	assign r_mag   = signed'(R_W'(q_sat));
	assign r_sgn   = neg_s2 ? -r_mag : r_mag;
	assign r_off   = r_sgn + R_W'(cfg.y_offset);
	assign r_clamp = (r_off > R_W'(QMAX)) ? ELEM_W'(QMAX)
		: (r_off < R_W'(QMIN)) ? ELEM_W'(QMIN) : r_off[ELEM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1      <= 1'b0;
			req_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			req_s1 <= cmd.req_go;
			req_s2 <= req_s1;
			if (req_s2) begin
				res_valid_q <= 1'b1;
			end else if (cmd.out_load) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_go) begin
			mul_s1 <= MUL_W'(mag) * MUL_W'(cfg.scale_mantissa);
			neg_s1 <= acc_q[ACC_W-1];
		end
		if (req_s1) begin
			sum_s2   <= SUM_W'(mul_s1) + (SUM_W'(1) << (tot_shift - 1'b1));
			shamt_s2 <= tot_shift[SHIFT_W-1:0];
			big_s2   <= int'(tot_shift) > MAX_SHIFT;
			neg_s2   <= neg_s1;
		end
		if (req_s2) begin
			res_q <= r_clamp;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= res_q;
			out_row_q   <= IDX_W'(cmd.row_idx);
			out_col_q   <= IDX_W'(cmd.col_idx);
			out_last_q  <= cmd.last;
		end
	end

	assign sts.mac_busy  = rd_s1 || prod_v_s2;
	assign sts.res_valid = res_valid_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

// ===== src/int8_quantized_matmul_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// int8_quantized_matmul_top: int8 matrix multiply with requantization
// Stream input of load and run commands, stream output of int8 results,
// register port for zero points, scale and matrix sizes.
// ----------------------------------------------------------------------------
// Usage:
// - the slave stream carries commands: tuser is the opcode (load A element,
//   load B element, run); a load writes one element into its store and gives
//   no result, one per cycle while no run is in flight
// - a run walks the output row-major and sends rows_used*cols_used words on
//   the master stream, tlast set on the final one
// - each result passes through one shared MAC lane, reading one element of
//   each store per cycle, a drain that waits for the MAC pipeline to empty,
//   and a three-stage requantizer
// - the first result word shows once its last MAC read has passed the MAC
//   pipeline, the requantizer stages and the output word register
// - the output word sits in a register; when the receiver stalls the
//   sequencer waits with the next result ready, and no command is taken
//   until the run's last result is loaded into the output word register
// - reset clears control state and loads the register reset values; store
//   contents are undefined until written, and no clearing pass is made
// - not enforced by the block: write registers only while no run is in flight
// ----------------------------------------------------------------------------
module int8_quantized_matmul_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// command stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// [2:0] row_index, [5:3] col_index, [13:6] element, [15:14] zero
	input  wire logic [qmm_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] opcode
	input  wire logic [qmm_pkg::OPC_W-1:0]    s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [7:0] product_value, [10:8] out_row, [13:11] out_col, [15:14] zero
	output logic [qmm_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                              m_tlast,
	// register port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [qmm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [qmm_pkg::DATA_W-1:0]   pwdata,
	output logic [qmm_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import qmm_pkg::*;

	cfg_t              cfg_q;
	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic              cfg_wr;
	reg_idx_t          reg_idx;
	logic [IDX_W-1:0]  in_row, in_col;
	logic [ELEM_W-1:0] in_element;
	logic [ELEM_W-1:0] out_value;
	logic [IDX_W-1:0]  out_row, out_col;

	// stream field unpacking
	assign in_row     = s_tdata[IDX_W-1:0];
	assign in_col     = s_tdata[2*IDX_W-1:IDX_W];
	assign in_element = s_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_offset       <= '0;
			cfg_q.b_offset       <= '0;
			cfg_q.y_offset       <= '0;
			cfg_q.scale_mantissa <= MANT_W'(1 << 30);
			cfg_q.scale_shift    <= '0;
			cfg_q.rows_used      <= fit_size(DATA_W'(8), MAX_ROWS);
			cfg_q.inner_used     <= fit_size(DATA_W'(8), MAX_INNER);
			cfg_q.cols_used      <= fit_size(DATA_W'(8), MAX_COLS);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_A_OFFSET:   cfg_q.a_offset       <= pwdata[ELEM_W-1:0];
				REG_B_OFFSET:   cfg_q.b_offset       <= pwdata[ELEM_W-1:0];
				REG_Y_OFFSET:   cfg_q.y_offset       <= pwdata[ELEM_W-1:0];
				REG_SCALE_MANT: cfg_q.scale_mantissa <= pwdata[MANT_W-1:0];
				REG_SCALE_SHFT: cfg_q.scale_shift    <= pwdata[SHIFT_W-1:0];
				REG_ROWS_USED:  cfg_q.rows_used      <= fit_size(pwdata, MAX_ROWS);
				REG_INNER_USED: cfg_q.inner_used     <= fit_size(pwdata, MAX_INNER);
				REG_COLS_USED:  cfg_q.cols_used      <= fit_size(pwdata, MAX_COLS);
				default:        cfg_q.a_offset       <= cfg_q.a_offset;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_A_OFFSET:   prdata = DATA_W'(cfg_q.a_offset);
			REG_B_OFFSET:   prdata = DATA_W'(cfg_q.b_offset);
			REG_Y_OFFSET:   prdata = DATA_W'(cfg_q.y_offset);
			REG_SCALE_MANT: prdata = DATA_W'(cfg_q.scale_mantissa);
			REG_SCALE_SHFT: prdata = DATA_W'(cfg_q.scale_shift);
			REG_ROWS_USED:  prdata = DATA_W'(cfg_q.rows_used);
			REG_INNER_USED: prdata = DATA_W'(cfg_q.inner_used);
			REG_COLS_USED:  prdata = DATA_W'(cfg_q.cols_used);
			default:        prdata = '0;
		endcase
	end

	qmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_opcode (s_tuser),
		.in_row    (in_row),
		.in_col    (in_col),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	qmm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.in_row     (in_row),
		.in_col     (in_col),
		.in_element (in_element),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_value  (out_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_last   (m_tlast)
	);

	// result word packing
	assign m_tdata = {{(M_DATA_W - ELEM_W - 2*IDX_W){1'b0}}, out_col, out_row, out_value};

	// a store is never written while a run reads it
	a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !(cmd.wr_a || cmd.wr_b))
		else $error("store write during a run");

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (sts.out_free && sts.res_valid))
		else $error("output word overwritten");

	// commands are only taken with the MAC and requantizer empty
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!sts.mac_busy && !sts.res_valid))
		else $error("command taken during a run");

	// requantizer starts only after the accumulator has settled
	a_req_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.req_go |-> !sts.mac_busy && !cmd.rd)
		else $error("requantize started on a busy accumulator");

endmodule
`default_nettype wire

// ===== sim/int8_quantized_matmul_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int8_quantized_matmul_top_tb: self-checking bench for the int8 matmul
// A short table of load, run and register steps comes first; its runs carry
// a hand-worked answer. Random phases follow: small matrices, new zero points,
// scales and sizes, bursty commands and a stalling receiver. Each result word
// is checked against its hand-worked answer or an in-bench requantized product.
// ----------------------------------------------------------------------------
module int8_quantized_matmul_top_tb;
	import qmm_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int SETTLE_CYCLES = 2 * (MAX_INNER + 7);
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 300;
	localparam int MAX_PRINT     = 40;
	localparam int WATCHDOG_NS   = 50_000_000;
	localparam int N_DIRECTED    = 34;
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	typedef enum logic {ROW_REG, ROW_CMD} row_kind_t;

	// one step of the directed table
	typedef struct packed {
		row_kind_t                kind;
		reg_idx_t                 idx;
		logic [DATA_W-1:0]        val;
		logic [OPC_W-1:0]         op;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [ELEM_W-1:0] elem;
		logic                     typed;
		logic signed [ELEM_W-1:0] want;
	} step_t;

	// one expected result word
	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last;
	} product_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata  = '0;
	logic [OPC_W-1:0]      s_tuser  = '0;
	logic                  m_tready = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [ADDR_W-1:0]     paddr    = '0;
	logic [DATA_W-1:0]     pwdata   = '0;
	wire logic             s_tready;
	wire logic             m_tvalid;
	wire logic [M_DATA_W-1:0] m_tdata;
	wire logic             m_tlast;
	wire logic [DATA_W-1:0] prdata;
	wire logic             pready;

	// register copy, reset values
	logic signed [ELEM_W-1:0] zp_a = '0;
	logic signed [ELEM_W-1:0] zp_b = '0;
	logic signed [ELEM_W-1:0] zp_y = '0;
	logic [MANT_W-1:0]        mult = 31'h4000_0000;
	logic [SHIFT_W-1:0]       shift_extra = '0;
	int                       rows_n  = MAX_ROWS;
	int                       inner_n = MAX_INNER;
	int                       cols_n  = MAX_COLS;

	// matrix copies and which entries the stimulus has written
	logic signed [ELEM_W-1:0] a_mat [A_DEPTH];
	logic signed [ELEM_W-1:0] b_mat [B_DEPTH];
	bit                       a_loaded [A_DEPTH];
	bit                       b_loaded [B_DEPTH];

	product_t pending_products [$];

	int errors       = 0;
	int words_seen   = 0;
	int work_items   = 0;
	int loads_done   = 0;
	int runs_done    = 0;
	int ignored_done = 0;
	int settings     = 0;
	int holds_done   = 0;
	int burst_left   = 0;

	step_t directed_steps [N_DIRECTED] = '{
		// one-element matrices: sizes zero act as one
		'{ROW_REG, REG_ROWS_USED,  32'd0, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_INNER_USED, 32'd1, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_COLS_USED,  32'd0, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		// positive and negative saturation
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_A, 3'd0, 3'd0, 8'sd127, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_B, 3'd0, 3'd0, 8'sd127, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, 8'sd127},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_B, 3'd0, 3'd0, -8'sd128, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd7, 3'd7, -8'sd1, 1'b1, -8'sd128},
		// half rounds away from zero
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_A, 3'd0, 3'd0, 8'sd1, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_B, 3'd0, 3'd0, 8'sd1, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, 8'sd1},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_B, 3'd0, 3'd0, -8'sd1, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, -8'sd1},
		// unused opcode must not touch the stores
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_UNUSED, 3'd0, 3'd0, 8'sd100, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, -8'sd1},
		// extreme zero points
		'{ROW_REG, REG_A_OFFSET, 32'h80, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_B_OFFSET, 32'h7F, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, -8'sd128},
		// scaled value rounds to zero, output is the y zero point
		'{ROW_REG, REG_Y_OFFSET,   32'd5,  OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_SCALE_SHFT, 32'd33, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, 8'sd5},
		'{ROW_REG, REG_SCALE_SHFT, 32'd0,  OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_SCALE_MANT, 32'd0,  OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, 8'sd5},
		'{ROW_REG, REG_SCALE_MANT, 32'h7FFF_FFFF, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_SCALE_SHFT, 32'd62, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, 8'sd5},
		'{ROW_REG, REG_SCALE_SHFT, 32'd63, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, 8'sd5},
		// full-scale multiplier, clamp at the bottom
		'{ROW_REG, REG_Y_OFFSET,   32'h80, OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_REG, REG_SCALE_SHFT, 32'd0,  OP_LOAD_A, 3'd0, 3'd0, 8'sd0, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_RUN,    3'd0, 3'd0, 8'sd0, 1'b1, -8'sd128},
		// far corners of both stores
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_A, 3'd7, 3'd7, -8'sd128, 1'b0, 8'sd0},
		'{ROW_CMD, REG_A_OFFSET, 32'd0, OP_LOAD_B, 3'd7, 3'd7, 8'sd127, 1'b0, 8'sd0}
	};

	int8_quantized_matmul_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// one line per mismatch, quiet after a while
	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINT) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	function automatic int clip_size(input logic [SIZE_W-1:0] v, input int top);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > top) begin
			return top;
		end
		return int'(v);
	endfunction

	// scale a sum by the q0.31 multiplier, round half away, offset, clamp
	function automatic logic signed [ELEM_W-1:0] requant(input longint acc);
		logic            neg;
		longint unsigned mag;
		longint unsigned q;
		int              s;
		int              r;
		neg = acc < 0;
		if (neg) begin
			mag = -acc;
		end else begin
			mag = acc;
		end
		mag = mag * mult;
		s = FRAC_BITS + int'(shift_extra);
		if (s > MAX_SHIFT) begin
			q = 0;
		end else begin
			q = (mag + (64'd1 << (s - 1))) >> s;
		end
		if (q > 1024) begin
			q = 1024;
		end
		r = int'(q);
		if (neg) begin
			r = -r;
		end
		r = r + int'(zp_y);
		if (r > QMAX) begin
			r = QMAX;
		end
		if (r < QMIN) begin
			r = QMIN;
		end
		return ELEM_W'(r);
	endfunction

	// update the matrix copies or queue the products of a run
	task automatic predict_cmd(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] e,
			input logic typed, input logic signed [ELEM_W-1:0] want);
		longint   acc;
		product_t w;
		case (op)
			OP_LOAD_A: begin
				a_mat[int'(r) * MAX_INNER + int'(c)] = e;
			end
			OP_LOAD_B: begin
				b_mat[int'(r) * MAX_COLS + int'(c)] = e;
			end
			OP_RUN: begin
				for (int i = 0; i < rows_n; i++) begin
					for (int j = 0; j < cols_n; j++) begin
						acc = 0;
						for (int k = 0; k < inner_n; k++) begin
							acc += (longint'(a_mat[i * MAX_INNER + k]) - longint'(zp_a)) *
								(longint'(b_mat[k * MAX_COLS + j]) - longint'(zp_b));
						end
						w.value = typed ? want : requant(acc);
						w.row   = IDX_W'(i);
						w.col   = IDX_W'(j);
						w.last  = (i == rows_n - 1) && (j == cols_n - 1);
						pending_products = {pending_products, w};
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// offer one command word, in bursts with random gaps
	task automatic send_word(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, e, c, r};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// send a command and predict what it causes
	task automatic issue_cmd(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] e,
			input logic typed, input logic signed [ELEM_W-1:0] want);
		if (op == OP_LOAD_A) begin
			a_loaded[int'(r) * MAX_INNER + int'(c)] = 1'b1;
		end
		if (op == OP_LOAD_B) begin
			b_loaded[int'(r) * MAX_COLS + int'(c)] = 1'b1;
		end
		send_word(op, r, c, e);
		if (op == OP_UNUSED) begin
			ignored_done++;
		end else begin
			work_items++;
			if (op == OP_RUN) begin
				runs_done++;
			end else begin
				loads_done++;
			end
		end
		predict_cmd(op, r, c, e, typed, want);
	endtask

	function automatic logic [ELEM_W-1:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'h00;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// fill whatever the run will read and has never been written, then run
	task automatic run_matmul();
		for (int i = 0; i < rows_n; i++) begin
			for (int k = 0; k < inner_n; k++) begin
				if (!a_loaded[i * MAX_INNER + k]) begin
					issue_cmd(OP_LOAD_A, IDX_W'(i), IDX_W'(k), rand_byte(), 1'b0, '0);
				end
			end
		end
		for (int k = 0; k < inner_n; k++) begin
			for (int j = 0; j < cols_n; j++) begin
				if (!b_loaded[k * MAX_COLS + j]) begin
					issue_cmd(OP_LOAD_B, IDX_W'(k), IDX_W'(j), rand_byte(), 1'b0, '0);
				end
			end
		end
		issue_cmd(OP_RUN, IDX_W'($urandom), IDX_W'($urandom), rand_byte(), 1'b0, '0);
	endtask

	// stop offering, wait for every word of the last run, let the block go idle
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup cycle, access cycle
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_A_OFFSET:   zp_a = val[ELEM_W-1:0];
			REG_B_OFFSET:   zp_b = val[ELEM_W-1:0];
			REG_Y_OFFSET:   zp_y = val[ELEM_W-1:0];
			REG_SCALE_MANT: mult = val[MANT_W-1:0];
			REG_SCALE_SHFT: shift_extra = val[SHIFT_W-1:0];
			REG_ROWS_USED:  rows_n = clip_size(val[SIZE_W-1:0], MAX_ROWS);
			REG_INNER_USED: inner_n = clip_size(val[SIZE_W-1:0], MAX_INNER);
			REG_COLS_USED:  cols_n = clip_size(val[SIZE_W-1:0], MAX_COLS);
			default: begin
			end
		endcase
	endtask

	// mostly small sizes, now and then zero, full or beyond the store
	function automatic logic [DATA_W-1:0] pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) begin
			return $urandom_range(1, 3);
		end else if (p < 85) begin
			return $urandom_range(4, 8);
		end else if (p < 92) begin
			return 0;
		end
		return $urandom_range(9, 15);
	endfunction

	// new register settings for a random phase
	task automatic shuffle_settings(input bit all);
		logic [DATA_W-1:0] v;
		if (all || $urandom_range(0, 1)) begin
			write_reg(REG_A_OFFSET, DATA_W'(rand_byte()));
		end
		if (all || $urandom_range(0, 1)) begin
			write_reg(REG_B_OFFSET, DATA_W'(rand_byte()));
		end
		if (all || $urandom_range(0, 1)) begin
			write_reg(REG_Y_OFFSET, DATA_W'(rand_byte()));
		end
		if (all || $urandom_range(0, 1)) begin
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'h4000_0000;
				3: v = $urandom & 32'h7FFF_FFFF;
				default: v = $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
			endcase
			write_reg(REG_SCALE_MANT, v);
		end
		if (all || $urandom_range(0, 1)) begin
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = $urandom_range(31, 33);
				2: v = 62;
				3: v = 63;
				4: v = $urandom_range(0, 63);
				default: v = $urandom_range(5, 12);
			endcase
			write_reg(REG_SCALE_SHFT, v);
		end
		if (all || $urandom_range(0, 1)) begin
			write_reg(REG_ROWS_USED, pick_size());
		end
		if (all || $urandom_range(0, 1)) begin
			write_reg(REG_INNER_USED, pick_size());
		end
		if (all || $urandom_range(0, 1)) begin
			write_reg(REG_COLS_USED, pick_size());
		end
		settings++;
	endtask

	// random loads that may land off the used region, and unused opcodes
	task automatic noise_cmd();
		case ($urandom_range(0, 2))
			0: issue_cmd(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_byte(), 1'b0, '0);
			1: issue_cmd(OP_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), rand_byte(), 1'b0, '0);
			default: issue_cmd(OP_LOAD_B, IDX_W'($urandom), IDX_W'($urandom), rand_byte(), 1'b0,
				'0);
		endcase
	endtask

	// result checker: every accepted word against the oldest expectation
	always @(posedge clk) begin
		product_t w;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (pending_products.size() == 0) begin
				report_mismatch($sformatf("result word %h with nothing pending", m_tdata));
			end else begin
				w = pending_products.pop_front();
				if ($signed(m_tdata[7:0]) != w.value) begin
					report_mismatch($sformatf("value at (%0d,%0d): got %0d expected %0d",
						w.row, w.col, $signed(m_tdata[7:0]), w.value));
				end
				if (m_tdata[10:8] != w.row) begin
					report_mismatch($sformatf("row: got %0d expected %0d", m_tdata[10:8], w.row));
				end
				if (m_tdata[13:11] != w.col) begin
					report_mismatch($sformatf("col: got %0d expected %0d", m_tdata[13:11], w.col));
				end
				if (m_tlast != w.last) begin
					report_mismatch($sformatf("last at (%0d,%0d): got %0b expected %0b",
						w.row, w.col, m_tlast, w.last));
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus long hold-offs while commands back up
	initial begin
		int seg_left;
		int mode;
		int hold_left;
		seg_left  = 0;
		mode      = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done < 2 && words_seen >= 30 + 600 * holds_done &&
					m_tvalid && s_tvalid && !s_tready) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(10, 80);
					mode = $urandom_range(0, 3);
				end
				seg_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// stimulus
	initial begin
		step_t st;
		int    dir_items;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int n = 0; n < N_DIRECTED; n++) begin
			st = directed_steps[n];
			if (st.kind == ROW_REG) begin
				settle();
				write_reg(st.idx, st.val);
			end else begin
				issue_cmd(st.op, st.row, st.col, st.elem, st.typed, st.want);
			end
		end
		dir_items = work_items;

		// random phases: new settings, then loads and runs
		while (work_items < dir_items + RANDOM_ITEMS) begin
			settle();
			shuffle_settings(settings == 0);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 7) == 0) begin
						noise_cmd();
					end else if ($urandom_range(0, 1)) begin
						issue_cmd(OP_LOAD_A, IDX_W'($urandom_range(0, rows_n - 1)),
							IDX_W'($urandom_range(0, inner_n - 1)), rand_byte(), 1'b0, '0);
					end else begin
						issue_cmd(OP_LOAD_B, IDX_W'($urandom_range(0, inner_n - 1)),
							IDX_W'($urandom_range(0, cols_n - 1)), rand_byte(), 1'b0, '0);
					end
				end
				run_matmul();
			end
		end

		// drain and wrap up
		settle();
		$display("covered %0d loads, %0d runs, %0d unused-opcode commands, %0d result words",
			loads_done, runs_done, ignored_done, words_seen);
		$display("over %0d random register settings with %0d long receiver hold-offs",
			settings, holds_done);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(WATCHDOG_NS);
		$display("timeout with %0d result words still pending", pending_products.size());
		$display("FAIL");
		$finish;
	end

endmodule
